// File: hdl/fdfp_pkg.sv
`default_nettype none
package fdfp_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] OpenCh  = 8'h23;
  localparam logic [7:0] CloseCh = 8'h24;
  localparam logic [7:0] SplitCh = 8'h2D;
  localparam logic [7:0] PlusCh  = 8'h2B;
  localparam logic [7:0] ZeroCh  = 8'h30;
  localparam logic [7:0] SpaceCh = 8'h20;
  localparam logic [7:0] TabCh   = 8'h09;
  localparam logic [7:0] CrCh    = 8'h0D;
  localparam logic [3:0] DigitSpan = 4'd9;

  // Register indexes of the configuration port.
  localparam logic RegFieldTypes = 1'b0;
  localparam logic RegFieldCount = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 2;

  // Field type codes of the schema.
  typedef enum logic [3:0] {
    FtU8   = 4'd0,
    FtU16  = 4'd1,
    FtU32  = 4'd2,
    FtI8   = 4'd3,
    FtI16  = 4'd4,
    FtI32  = 4'd5,
    FtBool = 4'd6
  } field_type_e;

  // Configuration registers as the front sees them.
  typedef struct packed {
    logic [31:0] field_types;
    logic [3:0]  field_count;
  } cfg_t;

  // One finished token, handed from the front to the back.
  typedef struct packed {
    logic [2:0]  number;
    logic [31:0] acc;
    logic        ovf;
    logic [3:0]  ftype;
    logic        zero_tok;
    logic        counted;
    logic        closing;
  } tok_rec_t;

endpackage
`default_nettype wire

// File: hdl/framed_decimal_field_parser_core.sv
// Framed decimal field parser.
// Input channel: one text byte per beat on byte_in_i, taken when push is high
// and full is low. Result channel: while empty is low, the oldest result sits
// on field_number_o, field_value_o, field_present_o and frame_end_o; it is
// taken when pop is high. Bytes outside a frame other than '#' give no result.
// Each nonempty token of the schema gives one result at its '-' or '$'; the
// closing '$' always gives one result, marked frame_end_o.
// Throughput is one byte per cycle while full is low: the front converts a
// digit per cycle with a multiply-by-ten and add. A result enters the token
// queue when its separator byte is taken, then the output register once it
// is empty or being popped. If the receiver stalls, results wait in the
// output register and the two-beat token queue; full rises only once the
// queue is full, and bytes are then held back. Reset clears the frame state,
// empties the queue and output, and sets field_types to 0 and field_count to
// 8. The user must write configuration through cfg_we_i, cfg_index_i and
// cfg_data_i only while the block is idle; the block does not enforce it.
`default_nettype none
module framed_decimal_field_parser_core import fdfp_pkg::*; #(
  parameter int unsigned MAX_FIELDS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        pop,
  output logic             empty,
  output logic [2:0]       field_number_o,
  output logic [31:0]      field_value_o,
  output logic             field_present_o,
  output logic             frame_end_o
);

  cfg_t     cfg_q;
  tok_rec_t front_rec, queue_rec;
  logic     front_push, queue_valid, back_take, take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_types <= 32'd0;
      cfg_q.field_count <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegFieldTypes: cfg_q.field_types <= cfg_data_i;
        RegFieldCount: cfg_q.field_count <= cfg_data_i[3:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // A pushed byte is taken whenever the queue has room for the token it may finish.
  assign take = push && !full;

  fdfp_front #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .take_i     (take),
    .byte_in_i  (byte_in_i),
    .rec_push_o (front_push),
    .rec_o      (front_rec)
  );

  fdfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_push),
    .wr_data_i (front_rec),
    .full_o    (full),
    .rd_i      (back_take),
    .valid_o   (queue_valid),
    .rd_data_o (queue_rec)
  );

  fdfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (queue_valid),
    .rec_i           (queue_rec),
    .rec_take_o      (back_take),
    .pop_i           (pop),
    .empty_o         (empty),
    .field_number_o  (field_number_o),
    .field_value_o   (field_value_o),
    .field_present_o (field_present_o),
    .frame_end_o     (frame_end_o)
  );

endmodule
`default_nettype wire

// File: hdl/fdfp_front.sv
`default_nettype none
module fdfp_front import fdfp_pkg::*; #(
  parameter int unsigned MAX_FIELDS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     take_i,
  input  wire logic [7:0] byte_in_i,
  output logic          rec_push_o,
  output tok_rec_t      rec_o
);

  localparam logic [3:0] MaxFieldsC = 4'(MAX_FIELDS);

  localparam logic [1:0] PhBlank = 2'd0;
  localparam logic [1:0] PhSign  = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  logic        in_frame_q, in_frame_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  len_q, len_d;
  logic        fz_q, fz_d;

  logic        is_digit, is_blank, is_sep, closing, in_schema;
  logic [3:0]  limit;
  logic [7:0]  dig_off;
  logic [35:0] prod;

  assign dig_off  = byte_in_i - ZeroCh;
  assign is_digit = (byte_in_i >= ZeroCh) && (dig_off <= {4'd0, DigitSpan});
  assign is_blank = (byte_in_i == SpaceCh) || ((byte_in_i >= TabCh) && (byte_in_i <= CrCh));
  assign closing  = (byte_in_i == CloseCh);
  assign is_sep   = closing || (byte_in_i == SplitCh);
  assign limit    = (cfg_i.field_count > MaxFieldsC) ? MaxFieldsC : cfg_i.field_count;
  assign in_schema = (len_q != 2'd0) && (cnt_q < limit);

  // Times ten as two shifted copies, plus the digit.
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, dig_off[3:0]};

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    phase_d    = phase_q;
    len_d      = len_q;
    fz_d       = fz_q;
    rec_push_o = 1'b0;

    rec_o.number   = cnt_q[2:0];
    rec_o.acc      = acc_q;
    rec_o.ovf      = ovf_q;
    rec_o.ftype    = cfg_i.field_types[cnt_q[2:0]*4 +: 4];
    rec_o.zero_tok = (len_q == 2'd1) && fz_q;
    rec_o.counted  = in_schema;
    rec_o.closing  = closing;

    if (take_i) begin
      if (!in_frame_q) begin
        if (byte_in_i == OpenCh) begin
          in_frame_d = 1'b1;
          cnt_d      = 4'd0;
          acc_d      = 32'd0;
          ovf_d      = 1'b0;
          phase_d    = PhBlank;
          len_d      = 2'd0;
          fz_d       = 1'b0;
        end
      end else if (is_sep) begin
        rec_push_o = in_schema || closing;
        if (in_schema) begin
          cnt_d = cnt_q + 4'd1;
        end
        if (closing) begin
          in_frame_d = 1'b0;
        end
        acc_d   = 32'd0;
        ovf_d   = 1'b0;
        phase_d = PhBlank;
        len_d   = 2'd0;
        fz_d    = 1'b0;
      end else begin
        if (len_q == 2'd0) begin
          fz_d = (byte_in_i == ZeroCh);
        end
        if (len_q != 2'd3) begin
          len_d = len_q + 2'd1;
        end
        if (phase_q != PhDone) begin
          if (is_digit) begin
            if (!ovf_q) begin
              if (prod[35:32] != 4'd0) begin
                ovf_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = prod[31:0];
              end
            end
            phase_d = PhDigit;
          end else if ((phase_q == PhBlank) && is_blank) begin
            phase_d = PhBlank;
          end else if ((phase_q == PhBlank) && (byte_in_i == PlusCh)) begin
            phase_d = PhSign;
          end else begin
            phase_d = PhDone;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= 4'd0;
      acc_q      <= 32'd0;
      ovf_q      <= 1'b0;
      phase_q    <= PhBlank;
      len_q      <= 2'd0;
      fz_q       <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      ovf_q      <= ovf_d;
      phase_q    <= phase_d;
      len_q      <= len_d;
      fz_q       <= fz_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/fdfp_queue.sv
`default_nettype none
module fdfp_queue import fdfp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire tok_rec_t wr_data_i,
  output logic          full_o,
  input  wire logic     rd_i,
  output logic          valid_o,
  output tok_rec_t      rd_data_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QDepth);
  localparam logic [PtrW-1:0] LastC  = PtrW'(QDepth - 1);

  tok_rec_t          mem_q [QDepth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == DepthC);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LastC) ? '0 : wp_q + PtrW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == LastC) ? '0 : rp_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/fdfp_back.sv
`default_nettype none
module fdfp_back import fdfp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     rec_valid_i,
  input  wire tok_rec_t rec_i,
  output logic          rec_take_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output logic [2:0]    field_number_o,
  output logic [31:0]   field_value_o,
  output logic          field_present_o,
  output logic          frame_end_o
);

  logic        out_valid_q;
  logic [2:0]  num_q;
  logic [31:0] val_q, val_d;
  logic        pres_q, pres_d;
  logic        end_q;
  logic [31:0] u_val, s_val;

  assign empty_o    = !out_valid_q;
  assign rec_take_o = rec_valid_i && (!out_valid_q || pop_i);

  assign u_val = rec_i.ovf ? 32'hFFFF_FFFF : rec_i.acc;
  assign s_val = (rec_i.ovf || rec_i.acc[31]) ? 32'h7FFF_FFFF : rec_i.acc;

  always_comb begin
    val_d  = 32'd0;
    pres_d = 1'b0;
    if (rec_i.counted) begin
      pres_d = 1'b1;
      unique case (rec_i.ftype)
        FtU8:    val_d = {24'd0, u_val[7:0]};
        FtU16:   val_d = {16'd0, u_val[15:0]};
        FtU32:   val_d = u_val;
        FtI8:    val_d = {{24{s_val[7]}}, s_val[7:0]};
        FtI16:   val_d = {{16{s_val[15]}}, s_val[15:0]};
        FtI32:   val_d = s_val;
        FtBool:  val_d = {31'd0, !rec_i.zero_tok};
        default: begin
          val_d  = 32'd0;
          pres_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      num_q  <= rec_i.number;
      val_q  <= val_d;
      pres_q <= pres_d;
      end_q  <= rec_i.closing;
    end
  end

  assign field_number_o  = num_q;
  assign field_value_o   = val_q;
  assign field_present_o = pres_q;
  assign frame_end_o     = end_q;

endmodule
`default_nettype wire
